// ----- design/mips_subset_execute_step_assert.svh -----
// Assertion macros for the MIPS subset execute step.
`ifndef MIPS_SUBSET_EXECUTE_STEP_ASSERT_SVH
`define MIPS_SUBSET_EXECUTE_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define MSE_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define MSE_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`else
`define MSE_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define MSE_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

// ----- design/mse_pkg.sv -----
// Shared types and constants for the MIPS subset execute step.
package mse_pkg;
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_BLEZ    = 6'd6;
    localparam logic [5:0] OP_BGTZ    = 6'd7;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_SW      = 6'd43;

    localparam logic [5:0] FN_SLL  = 6'd0;
    localparam logic [5:0] FN_SRL  = 6'd2;
    localparam logic [5:0] FN_JR   = 6'd8;
    localparam logic [5:0] FN_MFHI = 6'd16;
    localparam logic [5:0] FN_MFLO = 6'd18;
    localparam logic [5:0] FN_MULT = 6'd24;
    localparam logic [5:0] FN_DIV  = 6'd26;
    localparam logic [5:0] FN_ADD  = 6'd32;
    localparam logic [5:0] FN_SUB  = 6'd34;
    localparam logic [5:0] FN_AND  = 6'd36;
    localparam logic [5:0] FN_OR   = 6'd37;
    localparam logic [5:0] FN_XOR  = 6'd38;
    localparam logic [5:0] FN_SLT  = 6'd42;

    localparam logic [2:0] FAULT_OK      = 3'd0;
    localparam logic [2:0] FAULT_OVF     = 3'd1;
    localparam logic [2:0] FAULT_ADDR    = 3'd2;
    localparam logic [2:0] FAULT_UNKNOWN = 3'd3;
    localparam logic [2:0] FAULT_DIV0    = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_DIVFIX,
        ST_MEM, ST_LOAD, ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clr_step;
        logic take;      // latch instruction, start register reads
        logic exec;      // evaluate single-cycle ops
        logic mul_go;    // load HI/LO from the registered product
        logic div_start;
        logic div_step;
        logic div_fix;
        logic mem_go;    // memory access cycle
        logic load_wb;   // load data returned
        logic out_take;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic is_mul;
        logic is_div;
        logic is_mem;
        logic div_last;
    } t_sts;
endpackage

// ----- design/mips_subset_execute_step.sv -----
// Top level of the MIPS subset execute step.
//   channel | dir | payload
//   s_axis  | in  | tdata[31:0] instruction
//   m_axis  | out | tdata: next_pc[31:0], write_enable[32], write_index[37:33],
//           |     |        write_value[69:38], fault[72:70], zeros to 79
//   cfg     | in  | reset_pc, also loads the PC
// States per instruction: take, read, execute, result; MULT adds a product state, LW/SW
// add memory and load states, DIV adds divide steps (one quotient bit a cycle in the
// divider) and a fix-up state; the result state holds while the output stalls.
// A load, store or divide that faults takes the plain path. After reset a clearing pass
// zeroes the data memory before the first word is taken. One instruction is in flight at a time.
module mips_subset_execute_step
    import mse_pkg::*;
#(
    parameter int DATA_WORDS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // instruction
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // next_pc, write_enable, write_index, write_value, fault
);
    t_cmd cmd;
    t_sts sts;
    logic [31:0] next_pc, wval;
    logic        we;
    logic [4:0]  widx;
    logic [2:0]  fault;

    mse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_cmd      (cmd)
    );

    mse_dp #(.DATA_WORDS(DATA_WORDS)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_instr   (s_axis_tdata),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_next_pc (next_pc),
        .o_we      (we),
        .o_widx    (widx),
        .o_wval    (wval),
        .o_fault   (fault)
    );

    assign m_axis_tdata = {7'd0, fault, wval, widx, we, next_pc};
endmodule

// ----- design/mse_ram.sv -----
// Generic single-port RAM with registered read.
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

// ----- design/mse_ctrl.sv -----
// Controller state machine for the MIPS subset execute step.
`include "mips_subset_execute_step_assert.svh"
module mse_ctrl
    import mse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (i_sts.clr_done) n_state = ST_IDLE;
            ST_IDLE:   if (i_in_valid) n_state = ST_READ;
            ST_READ:   n_state = ST_EXEC;
            ST_EXEC: begin
                if (i_sts.is_mul) n_state = ST_MUL;
                else if (i_sts.is_div) n_state = ST_DIV;
                else if (i_sts.is_mem) n_state = ST_MEM;
                else n_state = ST_DONE;
            end
            ST_MUL:    n_state = ST_DONE;
            ST_DIV:    if (i_sts.div_last) n_state = ST_DIVFIX;
            ST_DIVFIX: n_state = ST_DONE;
            ST_MEM:    n_state = ST_LOAD;
            ST_LOAD:   n_state = ST_DONE;
            ST_DONE:   if (i_out_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_CLEAR:  o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.take  = i_in_valid;
            end
            ST_READ:   ;
            ST_EXEC: begin
                o_cmd.exec      = 1'b1;
                o_cmd.div_start = i_sts.is_div;
            end
            ST_MUL:    o_cmd.mul_go = 1'b1;
            ST_DIV:    o_cmd.div_step = 1'b1;
            ST_DIVFIX: o_cmd.div_fix = 1'b1;
            ST_MEM:    o_cmd.mem_go = 1'b1;
            ST_LOAD:   o_cmd.load_wb = 1'b1;
            ST_DONE: begin
                o_out_valid    = 1'b1;
                o_cmd.out_take = i_out_ready;
            end
            default:   ;
        endcase
    end

    `MSE_ASSERT_IMP(a_out_no_in, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `MSE_ASSERT_NXT(a_take_read, i_clk, i_rst_n, o_cmd.take, r_state == ST_READ)
    `MSE_ASSERT_IMP(a_one_go, i_clk, i_rst_n, 1'b1,
        $onehot0({o_cmd.mul_go, o_cmd.div_step, o_cmd.mem_go, o_cmd.exec}))
endmodule

// ----- design/mse_dp.sv -----
// Datapath: register file, HI/LO, ALU, multiplier, divider, data memory.
`include "mips_subset_execute_step_assert.svh"
module mse_dp
    import mse_pkg::*;
#(
    parameter int DATA_WORDS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic [31:0] i_instr,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [31:0] o_next_pc,
    output logic        o_we,
    output logic [4:0]  o_widx,
    output logic [31:0] o_wval,
    output logic [2:0]  o_fault
);
    localparam int AW = $clog2(DATA_WORDS);

    logic [31:0] r_rf [32];
    logic [31:0] r_pc, r_hi, r_lo, r_ins, r_a, r_b;
    logic [AW-1:0] r_clr;
    logic        r_clr_done;
    logic        r_we;
    logic [4:0]  r_widx;
    logic [31:0] r_wval;
    logic [2:0]  r_fault;
    logic [AW-1:0] r_midx;
    logic [31:0] r_prod_lo, r_prod_hi;

    // divider state
    logic [31:0] r_rem, r_quo, r_dvs;
    logic [5:0]  r_dcnt;
    logic        r_qneg, r_rneg;

    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sa;
    logic [15:0] imm;
    assign op  = r_ins[31:26];
    assign rs  = r_ins[25:21];
    assign rt  = r_ins[20:16];
    assign rd  = r_ins[15:11];
    assign sa  = r_ins[10:6];
    assign fn  = r_ins[5:0];
    assign imm = r_ins[15:0];

    logic [31:0] sx, pc4, boff;
    logic [32:0] sum, diff, addi;
    logic        addr_ok;
    assign sx    = {{16{imm[15]}}, imm};
    assign pc4   = r_pc + 32'd4;
    assign boff  = {sx[29:0], 2'b00};
    assign sum   = {r_a[31], r_a} + {r_b[31], r_b};
    assign diff  = {r_a[31], r_a} - {r_b[31], r_b};
    assign addi  = {r_a[31], r_a} + {sx[31], sx};
    assign addr_ok = !addi[32] && addi[1:0] == 2'b00
        && (addi[31:2] < 30'(DATA_WORDS));

    logic is_mul, is_div, is_mem_ld, is_mem_st;
    assign is_mul    = op == OP_SPECIAL && fn == FN_MULT;
    assign is_div    = op == OP_SPECIAL && fn == FN_DIV && r_b != 32'd0;
    assign is_mem_ld = op == OP_LW && addr_ok;
    assign is_mem_st = op == OP_SW && addr_ok;

    // single-cycle execute
    logic        e_we;
    logic [4:0]  e_idx;
    logic [31:0] e_val, e_pc;
    logic [2:0]  e_fault;
    always_comb begin
        e_we = 1'b0; e_idx = 5'd0; e_val = 32'd0; e_pc = pc4; e_fault = FAULT_OK;
        case (op)
            OP_SPECIAL: begin
                case (fn)
                    FN_SLL: if (r_ins != 32'd0) begin
                        e_we = 1'b1; e_idx = rd; e_val = r_b << sa;
                    end
                    FN_SRL: begin
                        e_we = 1'b1; e_idx = rd;
                        e_val = r_ins[21] ? ((r_b >> sa) | (r_b << (6'd32 - {1'b0, sa})))
                                          : (r_b >> sa);
                    end
                    FN_JR:   e_pc = r_a;
                    FN_MFHI: begin e_we = 1'b1; e_idx = rd; e_val = r_hi; end
                    FN_MFLO: begin e_we = 1'b1; e_idx = rd; e_val = r_lo; end
                    FN_MULT: ;
                    FN_DIV:  if (r_b == 32'd0) e_fault = FAULT_DIV0;
                    FN_ADD: begin
                        if (sum[32] != sum[31]) e_fault = FAULT_OVF;
                        else begin e_we = 1'b1; e_idx = rd; e_val = sum[31:0]; end
                    end
                    FN_SUB: begin
                        if (diff[32] != diff[31]) e_fault = FAULT_OVF;
                        else begin e_we = 1'b1; e_idx = rd; e_val = diff[31:0]; end
                    end
                    FN_AND: begin e_we = 1'b1; e_idx = rd; e_val = r_a & r_b; end
                    FN_OR:  begin e_we = 1'b1; e_idx = rd; e_val = r_a | r_b; end
                    FN_XOR: begin e_we = 1'b1; e_idx = rd; e_val = r_a ^ r_b; end
                    FN_SLT: begin e_we = 1'b1; e_idx = rd; e_val = {31'd0, diff[32]}; end
                    default: e_fault = FAULT_UNKNOWN;
                endcase
            end
            OP_J: e_pc = {pc4[31:28], r_ins[25:0], 2'b00};
            OP_JAL: begin
                e_pc = {pc4[31:28], r_ins[25:0], 2'b00};
                e_we = 1'b1; e_idx = 5'd31; e_val = pc4;
            end
            OP_BEQ:  if (r_a == r_b) e_pc = pc4 + boff;
            OP_BNE:  if (r_a != r_b) e_pc = pc4 + boff;
            OP_BLEZ: if (r_a[31] || r_a == 32'd0) e_pc = pc4 + boff;
            OP_BGTZ: if (!r_a[31] && r_a != 32'd0) e_pc = pc4 + boff;
            OP_ADDI: begin
                if (addi[32] != addi[31]) e_fault = FAULT_OVF;
                else begin e_we = 1'b1; e_idx = rt; e_val = addi[31:0]; end
            end
            OP_LUI: begin e_we = 1'b1; e_idx = rt; e_val = {imm, 16'd0}; end
            OP_LW: if (!addr_ok) e_fault = FAULT_ADDR;
            OP_SW: if (!addr_ok) e_fault = FAULT_ADDR;
            default: e_fault = FAULT_UNKNOWN;
        endcase
    end

    // memory: clear sweep, then normal use
    logic          m_we;
    logic [AW-1:0] m_addr;
    logic [31:0]   m_wdata, m_rdata;
    always_comb begin
        m_we = 1'b0; m_addr = r_midx; m_wdata = r_b;
        if (i_cmd.clr_step) begin
            m_we = 1'b1; m_addr = r_clr; m_wdata = 32'd0;
        end else if (i_cmd.mem_go) begin
            m_we = op == OP_SW;
        end
    end

    mse_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_mem (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_addr (m_addr),
        .i_wdata(m_wdata),
        .o_rdata(m_rdata)
    );

    // restoring divide on magnitudes, one bit a cycle
    logic [31:0] abs_a, abs_b;
    logic [32:0] trial;
    assign abs_a = r_a[31] ? (32'd0 - r_a) : r_a;
    assign abs_b = r_b[31] ? (32'd0 - r_b) : r_b;
    assign trial = {r_rem, r_quo[31]} - {1'b0, r_dvs};

    logic signed [63:0] prod;
    assign prod = $signed(r_a) * $signed(r_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clr_done <= 1'b0;
            r_pc       <= 32'd0;
            r_hi       <= 32'd0;
            r_lo       <= 32'd0;
            for (int i = 0; i < 32; i++) r_rf[i] <= 32'd0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == AW'(DATA_WORDS - 1)) r_clr_done <= 1'b1;
            end
            if (i_cfg_we) r_pc <= i_cfg_data;
            if (i_cmd.take) r_ins <= i_instr;
            if (i_cmd.exec) begin
                r_pc    <= e_pc;
                r_we    <= e_we && e_idx != 5'd0;
                r_widx  <= (e_we && e_idx != 5'd0) ? e_idx : 5'd0;
                r_wval  <= (e_we && e_idx != 5'd0) ? e_val : 32'd0;
                r_fault <= e_fault;
                r_midx  <= addi[AW+1:2];
                if (e_we && e_idx != 5'd0) r_rf[e_idx] <= e_val;
                r_prod_lo <= prod[31:0];
                r_prod_hi <= prod[63:32];
            end
            if (i_cmd.mul_go) begin
                r_hi <= r_prod_hi;
                r_lo <= r_prod_lo;
            end
            if (i_cmd.div_start) begin
                r_rem  <= 32'd0;
                r_quo  <= abs_a;
                r_dvs  <= abs_b;
                r_dcnt <= 6'd0;
                r_qneg <= r_a[31] ^ r_b[31];
                r_rneg <= r_a[31];
            end
            if (i_cmd.div_step) begin
                if (!trial[32]) begin
                    r_rem <= trial[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[30:0], r_quo[31]};
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_dcnt <= r_dcnt + 6'd1;
            end
            if (i_cmd.div_fix) begin
                r_lo <= r_qneg ? (32'd0 - r_quo) : r_quo;
                r_hi <= r_rneg ? (32'd0 - r_rem) : r_rem;
            end
            if (i_cmd.load_wb && op == OP_LW && rt != 5'd0) begin
                r_rf[rt] <= m_rdata;
                r_we     <= 1'b1;
                r_widx   <= rt;
                r_wval   <= m_rdata;
            end
        end
    end

    // register reads, with register zero forced to zero
    always_ff @(posedge i_clk) begin
        r_a <= (rs == 5'd0) ? 32'd0 : r_rf[rs];
        r_b <= (rt == 5'd0) ? 32'd0 : r_rf[rt];
    end

    assign o_sts.clr_done = r_clr_done;
    assign o_sts.is_mul   = is_mul;
    assign o_sts.is_div   = is_div;
    assign o_sts.is_mem   = is_mem_ld || is_mem_st;
    assign o_sts.div_last = r_dcnt == 6'd31;

    assign o_next_pc = r_pc;
    assign o_we      = r_we;
    assign o_widx    = r_widx;
    assign o_wval    = r_wval;
    assign o_fault   = r_fault;

    `MSE_ASSERT_IMP(a_rf0_zero, i_clk, i_rst_n, 1'b1, r_rf[0] == 32'd0)
    `MSE_ASSERT_IMP(a_we_idx, i_clk, i_rst_n, i_cmd.out_take, r_we == (r_widx != 5'd0))
    `MSE_ASSERT_IMP(a_fault_nowr, i_clk, i_rst_n, i_cmd.out_take && r_fault != FAULT_OK,
        !r_we)
endmodule
